[rtl/b32kse_pkg.sv]
package b32kse_pkg;

	// Sequencer phases of the string encoder
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_PREFIX,
		PH_SYM,
		PH_PAD,
		PH_ZERO,
		PH_CHK
	} phase_t;

	localparam int LEAD_LEN = 16;
	localparam int CHK_SYMS = 6;
	localparam int HRP_LEN  = 15;

	localparam logic [29:0] GEN_POLY [5] = '{
		30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
	};

	// Upper-case leading text, the human-readable part plus separator
	localparam logic [6:0] LEAD_TEXT [LEAD_LEN] = '{
		7'h41, 7'h47, 7'h45, 7'h2d, 7'h53, 7'h45, 7'h43, 7'h52,
		7'h45, 7'h54, 7'h2d, 7'h4b, 7'h45, 7'h59, 7'h2d, 7'h31
	};

	localparam logic [255:0] SYM_UPPER = "QPZRY9X8GF2TVDW0S3JN54KHCE6MUA7L";

	// One polymod step: shift in a 5-bit value, fold the top five bits back in
	function automatic logic [29:0] poly_step(logic [29:0] c, logic [4:0] v);
		logic [4:0]  top;
		logic [29:0] r;
		top = c[29:25];
		r   = {c[24:0], v};
		for (int i = 0; i < 5; i++) begin
			if (top[i]) begin
				r = r ^ GEN_POLY[i];
			end
		end
		return r;
	endfunction

	function automatic logic [6:0] sym_char(logic [4:0] s);
		logic [7:0] ch;
		ch = SYM_UPPER[8 * (31 - int'(s)) +: 8];
		return ch[6:0];
	endfunction

	function automatic logic [6:0] to_lower(logic [6:0] ch);
		return (ch >= 7'h41 && ch <= 7'h5a) ? (ch | 7'h20) : ch;
	endfunction

	// Checksum state after the expanded lower-case human-readable part
	function automatic logic [29:0] prefix_state();
		logic [29:0] c;
		logic [6:0]  lc;
		c = 30'd1;
		for (int i = 0; i < HRP_LEN; i++) begin
			lc = to_lower(LEAD_TEXT[i]);
			c  = poly_step(c, {3'b000, lc[6:5]});
		end
		c = poly_step(c, 5'd0);
		for (int i = 0; i < HRP_LEN; i++) begin
			lc = to_lower(LEAD_TEXT[i]);
			c  = poly_step(c, lc[4:0]);
		end
		return c;
	endfunction

	localparam logic [29:0] PREFIX_STATE = prefix_state();

endpackage

[rtl/bech32_key_string_encoder_top.sv]
// An accepted key byte waits in the input register until the idle sequencer takes it and loads
//   its first character into the output register. One character can leave per cycle while
//   char_ready is high, except in the polymod zero steps. A byte gives one or two 5-bit symbols;
//   a key's first byte adds 16 leading characters, its last a pad symbol if bits are left over,
//   six polymod zero steps and six checksum characters, all through one shared polymod step.
// Reset (arst_n low): empty input and output registers, checksum_xor = 1, ready for a new key.
module bech32_key_string_encoder_top #(
	parameter int KEY_LEN = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        checksum_xor_wr_en,
	input  logic [29:0] checksum_xor,
	input  logic        key_valid,
	output logic        key_ready,
	input  logic [7:0]  key_byte,
	output logic        char_valid,
	input  logic        char_ready,
	output logic [6:0]  char_code,
	output logic        last_char
);

	localparam int SeenW = (KEY_LEN > 1) ? $clog2(KEY_LEN) : 1;
	localparam logic [SeenW-1:0] LastSeen = SeenW'(KEY_LEN - 1);
	localparam logic [3:0] LastLead = 4'(b32kse_pkg::LEAD_LEN - 1);
	localparam logic [3:0] LastChk  = 4'(b32kse_pkg::CHK_SYMS - 1);

	// Control state
	b32kse_pkg::phase_t phase_q, phase_d;
	logic [3:0]       cnt_q, cnt_d;
	logic [SeenW-1:0] bytes_seen_q, bytes_seen_d;
	logic [3:0]       nbits_q, nbits_d;
	logic [29:0]      chk_q, chk_d;
	logic [29:0]      checksum_xor_q;
	logic             hold_valid_q;
	logic             out_valid_q, out_valid_d;

	// Payload registers
	logic [7:0]  hold_byte_q;
	logic [11:0] bit_buf_q, bit_buf_d;
	logic [6:0]  char_code_q, char_code_d;
	logic        last_char_q, last_char_d;

	// Datapath
	logic        adv, consume, emit;
	logic        first_byte, last_byte, sym_done;
	logic [11:0] ld_buf, src_buf, sym_shift;
	logic [3:0]  ld_nbits, src_nbits, nbits_after;
	logic [4:0]  data_sym, pad_sym, step_sym;
	logic [16:0] pad_ext;
	logic [29:0] chk_stepped;
	b32kse_pkg::phase_t after_sym_phase;

	// The output register may be loaded when empty or being drained this cycle
	assign adv     = !out_valid_q || char_ready;
	assign consume = (phase_q == b32kse_pkg::PH_IDLE) && hold_valid_q && adv;
	assign emit    = adv && (phase_q != b32kse_pkg::PH_ZERO)
	                 && ((phase_q != b32kse_pkg::PH_IDLE) || hold_valid_q);

	// Input register: take a new transaction when empty or when the held byte leaves this cycle
	assign key_ready = !hold_valid_q || consume;

	assign first_byte = (bytes_seen_q == '0);
	assign last_byte  = (bytes_seen_q >= LastSeen);

	// Regroup: append the held byte below the leftover bits, then peel 5-bit symbols off the top
	assign ld_buf      = {bit_buf_q[3:0], hold_byte_q};
	assign ld_nbits    = nbits_q + 4'd8;
	assign src_buf     = (phase_q == b32kse_pkg::PH_IDLE) ? ld_buf : bit_buf_q;
	assign src_nbits   = (phase_q == b32kse_pkg::PH_IDLE) ? ld_nbits : nbits_q;
	assign nbits_after = src_nbits - 4'd5;
	assign sym_shift   = src_buf >> nbits_after;
	assign data_sym    = sym_shift[4:0];

	// Zero-padded final symbol from the leftover bits
	assign pad_ext = 17'(bit_buf_q) << (4'd5 - nbits_q);
	assign pad_sym = pad_ext[4:0];

	// One shared polymod step per cycle
	always_comb begin
		case (phase_q)
			b32kse_pkg::PH_PAD:  step_sym = pad_sym;
			b32kse_pkg::PH_ZERO: step_sym = 5'd0;
			default:             step_sym = data_sym;
		endcase
	end
	assign chk_stepped = b32kse_pkg::poly_step(chk_q, step_sym);

	// Where to go once a data symbol has left
	always_comb begin
		if (nbits_after >= 4'd5) begin
			after_sym_phase = b32kse_pkg::PH_SYM;
		end else if (!last_byte || first_byte) begin
			// a one-byte key drops its pad and checksum, so it ends here too
			after_sym_phase = b32kse_pkg::PH_IDLE;
		end else if (nbits_after != 4'd0) begin
			after_sym_phase = b32kse_pkg::PH_PAD;
		end else begin
			after_sym_phase = b32kse_pkg::PH_ZERO;
		end
	end

	// Next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			b32kse_pkg::PH_IDLE: begin
				if (consume) begin
					phase_d = first_byte ? b32kse_pkg::PH_PREFIX : after_sym_phase;
				end
			end
			b32kse_pkg::PH_PREFIX: begin
				if (adv && cnt_q == LastLead) begin
					phase_d = b32kse_pkg::PH_SYM;
				end
			end
			b32kse_pkg::PH_SYM: begin
				if (adv) begin
					phase_d = after_sym_phase;
				end
			end
			b32kse_pkg::PH_PAD: begin
				if (adv) begin
					phase_d = b32kse_pkg::PH_ZERO;
				end
			end
			b32kse_pkg::PH_ZERO: begin
				if (cnt_q == LastChk) begin
					phase_d = b32kse_pkg::PH_CHK;
				end
			end
			b32kse_pkg::PH_CHK: begin
				if (adv && cnt_q == LastChk) begin
					phase_d = b32kse_pkg::PH_IDLE;
				end
			end
			default: phase_d = b32kse_pkg::PH_IDLE;
		endcase
	end

	// Datapath and output character
	always_comb begin
		cnt_d        = cnt_q;
		bytes_seen_d = bytes_seen_q;
		nbits_d      = nbits_q;
		chk_d        = chk_q;
		bit_buf_d    = bit_buf_q;
		char_code_d  = char_code_q;
		last_char_d  = last_char_q;
		sym_done     = 1'b0;
		unique case (phase_q)
			b32kse_pkg::PH_IDLE: begin
				if (consume) begin
					bit_buf_d   = ld_buf;
					last_char_d = 1'b0;
					if (first_byte) begin
						char_code_d = b32kse_pkg::LEAD_TEXT[0];
						nbits_d     = ld_nbits;
						cnt_d       = 4'd1;
					end else begin
						char_code_d = b32kse_pkg::sym_char(data_sym);
						chk_d       = chk_stepped;
						nbits_d     = nbits_after;
						sym_done    = 1'b1;
					end
				end
			end
			b32kse_pkg::PH_PREFIX: begin
				if (adv) begin
					char_code_d = b32kse_pkg::LEAD_TEXT[cnt_q];
					last_char_d = 1'b0;
					cnt_d       = cnt_q + 4'd1;
				end
			end
			b32kse_pkg::PH_SYM: begin
				if (adv) begin
					char_code_d = b32kse_pkg::sym_char(data_sym);
					last_char_d = 1'b0;
					chk_d       = chk_stepped;
					nbits_d     = nbits_after;
					sym_done    = 1'b1;
				end
			end
			b32kse_pkg::PH_PAD: begin
				if (adv) begin
					char_code_d = b32kse_pkg::sym_char(pad_sym);
					last_char_d = 1'b0;
					chk_d       = chk_stepped;
					nbits_d     = 4'd0;
					cnt_d       = 4'd0;
				end
			end
			b32kse_pkg::PH_ZERO: begin
				// six zero steps, then fold in the configured constant
				cnt_d = cnt_q + 4'd1;
				chk_d = chk_stepped;
				if (cnt_q == LastChk) begin
					chk_d = chk_stepped ^ checksum_xor_q;
					cnt_d = 4'd0;
				end
			end
			b32kse_pkg::PH_CHK: begin
				if (adv) begin
					char_code_d = b32kse_pkg::sym_char(chk_q[29:25]);
					last_char_d = (cnt_q == LastChk);
					chk_d       = {chk_q[24:0], 5'd0};
					cnt_d       = cnt_q + 4'd1;
					if (cnt_q == LastChk) begin
						cnt_d        = 4'd0;
						bytes_seen_d = '0;
						nbits_d      = 4'd0;
						chk_d        = b32kse_pkg::PREFIX_STATE;
					end
				end
			end
			default: ;
		endcase

		// Byte fully drained: advance the count, or end a one-byte key right away
		if (sym_done && nbits_after < 4'd5) begin
			if (!last_byte) begin
				bytes_seen_d = SeenW'(bytes_seen_q + 1'b1);
			end else if (first_byte) begin
				bytes_seen_d = '0;
				nbits_d      = 4'd0;
				chk_d        = b32kse_pkg::PREFIX_STATE;
			end
		end
	end

	always_comb begin
		if (emit) begin
			out_valid_d = 1'b1;
		end else if (char_ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= b32kse_pkg::PH_IDLE;
			cnt_q          <= 4'd0;
			bytes_seen_q   <= '0;
			nbits_q        <= 4'd0;
			chk_q          <= b32kse_pkg::PREFIX_STATE;
			checksum_xor_q <= 30'd1;
			hold_valid_q   <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			phase_q      <= phase_d;
			cnt_q        <= cnt_d;
			bytes_seen_q <= bytes_seen_d;
			nbits_q      <= nbits_d;
			chk_q        <= chk_d;
			out_valid_q  <= out_valid_d;
			if (checksum_xor_wr_en) begin
				checksum_xor_q <= checksum_xor;
			end
			if (key_valid && key_ready) begin
				hold_valid_q <= 1'b1;
			end else if (consume) begin
				hold_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (key_valid && key_ready) begin
			hold_byte_q <= key_byte;
		end
		bit_buf_q   <= bit_buf_d;
		char_code_q <= char_code_d;
		last_char_q <= last_char_d;
	end

	assign char_valid = out_valid_q;
	assign char_code  = char_code_q;
	assign last_char  = last_char_q;

	// Between bytes fewer than five bits may be left over
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == b32kse_pkg::PH_IDLE) |-> (nbits_q < 4'd5))
		else $error("leftover bit count too large while waiting for a byte");

	// A held byte that is not consumed stays put
	assert property (@(posedge clk) disable iff (!arst_n)
		(hold_valid_q && !consume) |=> (hold_valid_q && $stable(hold_byte_q)))
		else $error("held key byte lost before use");

	// The final checksum character returns the encoder to a clean start
	assert property (@(posedge clk) disable iff (!arst_n)
		(emit && phase_q == b32kse_pkg::PH_CHK && cnt_q == LastChk) |=>
		(phase_q == b32kse_pkg::PH_IDLE && bytes_seen_q == '0 && nbits_q == 4'd0
		 && chk_q == b32kse_pkg::PREFIX_STATE && last_char_q))
		else $error("string end did not clear encoder state");

	// Checksum counting stays within six steps
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == b32kse_pkg::PH_ZERO || phase_q == b32kse_pkg::PH_CHK) |-> (cnt_q <= LastChk))
		else $error("checksum step count out of range");

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps

module testbench;

	localparam int          KEY_LEN     = 32;
	localparam int          MAX_CHARS   = 17;
	localparam int          CYCLE_LIMIT = 200000;
	localparam int          LONG_HOLD   = 300;
	localparam logic [29:0] XOR_BECH32  = 30'd1;
	localparam logic [29:0] XOR_BECH32M = 30'h2bc830a3;
	localparam logic [29:0] XOR_ALL_SET = 30'h3fffffff;

	// Text in front of every key string, as ASCII codes
	localparam logic [127:0] LEAD_CODES =
		128'h41_47_45_2d_53_45_43_52_45_54_2d_4b_45_59_2d_31;
	localparam logic [255:0] ALPHABET = "QPZRY9X8GF2TVDW0S3JN54KHCE6MUA7L";
	localparam logic [135:0] NO_TEXT = 136'h0;

	// Directed rows: key byte, then the literal characters it must produce.
	// A row with no literal text is checked against the encoder prediction.
	localparam logic [143:0] DIRECTED [24] = '{
		{8'h00, LEAD_CODES, 8'h51},	// fresh key: leading text plus symbol zero
		{8'hff, 120'h0, "RL"},		// all ones on three leftover zero bits
		{8'h00, NO_TEXT},
		{8'h80, NO_TEXT},
		{8'h01, NO_TEXT},
		{8'h7f, NO_TEXT},
		{8'hfe, NO_TEXT},
		{8'haa, NO_TEXT},
		{8'h55, NO_TEXT},
		{8'hff, NO_TEXT},
		{8'hff, NO_TEXT},
		{8'hff, NO_TEXT},
		{8'h00, NO_TEXT},
		{8'h00, NO_TEXT},
		{8'h00, NO_TEXT},
		{8'h01, NO_TEXT},
		{8'h02, NO_TEXT},
		{8'h04, NO_TEXT},
		{8'h08, NO_TEXT},
		{8'h10, NO_TEXT},
		{8'h20, NO_TEXT},
		{8'h40, NO_TEXT},
		{8'h80, NO_TEXT},
		{8'hc3, NO_TEXT}
	};

	typedef struct packed {
		logic [6:0] code;
		logic       last;
	} char_t;

	logic        clk;
	logic        arst_n;
	logic        checksum_xor_wr_en;
	logic [29:0] checksum_xor;
	logic        key_valid;
	logic        key_ready;
	logic [7:0]  key_byte;
	logic        char_valid;
	logic        char_ready;
	logic [6:0]  char_code;
	logic        last_char;

	// Encoder prediction state
	logic [29:0] xor_setting;
	logic [29:0] crc_seed;
	logic [29:0] crc_state;
	logic [11:0] pend_bits;
	int          pend_count;
	int          key_pos;
	char_t       step_chars [MAX_CHARS];
	int          step_count;

	char_t       expected_chars [$];
	char_t       want_char;
	int          bad_chars   = 0;
	int          chars_taken = 0;
	int          cycle_count = 0;
	bit          traffic_gaps;

	bech32_key_string_encoder_top dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.checksum_xor_wr_en (checksum_xor_wr_en),
		.checksum_xor       (checksum_xor),
		.key_valid          (key_valid),
		.key_ready          (key_ready),
		.key_byte           (key_byte),
		.char_valid         (char_valid),
		.char_ready         (char_ready),
		.char_code          (char_code),
		.last_char          (last_char)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Shift one 5-bit value into the BCH checksum, folding back the five bits
	// that fall off the top through the generator terms.
	function automatic logic [29:0] polymod_shift(logic [29:0] c, logic [4:0] v);
		logic [29:0] r;
		r = {c[24:0], v};
		if (c[25]) r = r ^ 30'h3b6a57b2;
		if (c[26]) r = r ^ 30'h26508e6d;
		if (c[27]) r = r ^ 30'h1ea119fa;
		if (c[28]) r = r ^ 30'h3d4233dd;
		if (c[29]) r = r ^ 30'h2a1462b3;
		return r;
	endfunction

	function automatic logic [6:0] symbol_char(logic [4:0] s);
		return ALPHABET[8 * (31 - s) +: 7];
	endfunction

	// Checksum after the expanded lower-case prefix (leading text minus the
	// separator): high bits of every character, a zero, then the low bits.
	function automatic logic [29:0] prefix_checksum();
		logic [29:0] c;
		logic [7:0]  ch;
		c = 30'd1;
		for (int i = 0; i < 15; i++) begin
			ch = LEAD_CODES[8 * (15 - i) +: 8];
			if (ch >= 8'h41 && ch <= 8'h5a) ch = ch | 8'h20;
			c = polymod_shift(c, {2'b00, ch[7:5]});
		end
		c = polymod_shift(c, 5'd0);
		for (int i = 0; i < 15; i++) begin
			ch = LEAD_CODES[8 * (15 - i) +: 8];
			if (ch >= 8'h41 && ch <= 8'h5a) ch = ch | 8'h20;
			c = polymod_shift(c, ch[4:0]);
		end
		return c;
	endfunction

	task automatic restart_string();
		key_pos    = 0;
		pend_bits  = '0;
		pend_count = 0;
		crc_state  = crc_seed;
	endtask

	// Drop anything past the most characters one key byte may produce
	task automatic emit_char(input logic [6:0] code, input logic last);
		if (step_count < MAX_CHARS) begin
			step_chars[step_count] = '{code: code, last: last};
			step_count++;
		end
	endtask

	task automatic emit_symbol(input logic [4:0] sym);
		crc_state = polymod_shift(crc_state, sym);
		emit_char(symbol_char(sym), 1'b0);
	endtask

	// Work out the characters that one key byte produces
	task automatic encode_byte(input logic [7:0] b);
		logic [29:0] pm;
		logic [4:0]  sym;
		bit          closing;
		step_count = 0;
		closing    = (key_pos + 1 >= KEY_LEN);
		if (key_pos == 0) begin
			for (int i = 15; i >= 0; i--) begin
				emit_char(LEAD_CODES[8 * i +: 7], 1'b0);
			end
		end
		pend_bits  = {pend_bits[3:0], b};
		pend_count = pend_count + 8;
		while (pend_count >= 5) begin
			pend_count = pend_count - 5;
			emit_symbol(pend_bits[pend_count +: 5]);
		end
		pend_bits = pend_bits & ((12'd1 << pend_count) - 12'd1);
		if (!closing) begin
			key_pos = (key_pos + 1) & 63;
		end else begin
			// pad the last symbol with zeros, then six checksum characters
			if (pend_count > 0) begin
				sym = pend_bits[4:0] << (5 - pend_count);
				emit_symbol(sym);
			end
			pm = crc_state;
			for (int i = 0; i < 6; i++) begin
				pm = polymod_shift(pm, 5'd0);
			end
			pm = pm ^ xor_setting;
			for (int i = 0; i < 6; i++) begin
				emit_char(symbol_char(pm[5 * (5 - i) +: 5]), i == 5);
			end
			restart_string();
		end
	endtask

	// Offer one key byte, hold it until the transaction completes, then queue
	// the characters it must produce. Literal text, where given, overrides.
	task automatic send_key_byte(input logic [7:0] b, input logic [135:0] text);
		int gap;
		if (traffic_gaps && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 8);
			key_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		key_valid <= 1'b1;
		key_byte  <= b;
		@(posedge clk);
		while (!key_ready) @(posedge clk);
		encode_byte(b);
		if (text == NO_TEXT) begin
			for (int i = 0; i < step_count; i++) begin
				expected_chars.insert(expected_chars.size(), step_chars[i]);
			end
		end else begin
			for (int i = 16; i >= 0; i--) begin
				if (text[8 * i +: 8] != 8'h00) begin
					expected_chars.insert(expected_chars.size(),
						char_t'{code: text[8 * i +: 7], last: 1'b0});
				end
			end
		end
		@(negedge clk);
	endtask

	// Let every queued character drain before touching the register
	task automatic wait_drained();
		while (expected_chars.size() != 0) @(negedge clk);
	endtask

	// Mostly random bytes, with the all-zero and all-one extremes mixed in
	function automatic logic [7:0] random_key_byte();
		int pick;
		pick = $urandom_range(0, 7);
		if (pick == 0) return 8'h00;
		if (pick == 1) return 8'hff;
		return 8'($urandom_range(0, 255));
	endfunction

	// Stimulus: reset, directed rows, then one key per register setting
	initial begin
		logic [29:0] next_xor;
		arst_n             = 1'b0;
		checksum_xor_wr_en = 1'b0;
		checksum_xor       = '0;
		key_valid          = 1'b0;
		key_byte           = '0;
		traffic_gaps       = 1'b1;
		xor_setting        = XOR_BECH32;
		crc_seed           = prefix_checksum();
		restart_string();

		// hold reset low, then release it away from the rising edge
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// first key runs on the reset value of the register
		for (int row = 0; row < 24; row++) begin
			send_key_byte(DIRECTED[row][143:136], DIRECTED[row][135:0]);
		end
		for (int n = 24; n < KEY_LEN; n++) begin
			send_key_byte(random_key_byte(), NO_TEXT);
		end

		// one full key per setting; the last key runs without any idling
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0:       next_xor = XOR_BECH32M;
				1:       next_xor = '0;
				2:       next_xor = XOR_ALL_SET;
				5:       next_xor = XOR_BECH32;
				default: next_xor = 30'($urandom_range(0, XOR_ALL_SET));
			endcase
			key_valid <= 1'b0;
			wait_drained();
			repeat (4) @(negedge clk);
			checksum_xor_wr_en <= 1'b1;
			checksum_xor       <= next_xor;
			@(negedge clk);
			checksum_xor_wr_en <= 1'b0;
			xor_setting  = next_xor;
			traffic_gaps = (phase == 5) ? 1'b0 : ($urandom_range(0, 3) != 0);
			for (int n = 0; n < KEY_LEN; n++) begin
				send_key_byte(random_key_byte(), NO_TEXT);
			end
		end
		key_valid <= 1'b0;

		// wait out the tail, then catch any stray characters
		wait_drained();
		repeat (20) @(posedge clk);
		if (bad_chars == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Receiver: random stall bursts, plus one long hold-off once the stream is
	// well under way, so the encoder backs up and stops taking key bytes.
	initial begin
		int  stall;
		int  long_left;
		bit  long_done;
		stall     = 0;
		long_left = 0;
		long_done = 1'b0;
		char_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_left > 0) begin
				long_left--;
				char_ready <= 1'b0;
			end else if (!long_done && chars_taken >= 100) begin
				long_done = 1'b1;
				long_left = LONG_HOLD - 1;
				char_ready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				char_ready <= 1'b0;
			end else if (traffic_gaps && $urandom_range(0, 4) == 0) begin
				stall = $urandom_range(1, 8) - 1;
				char_ready <= 1'b0;
			end else begin
				char_ready <= 1'b1;
			end
		end
	end

	// Compare every character transaction against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && char_valid && char_ready) begin
			chars_taken++;
			if (expected_chars.size() == 0) begin
				if (bad_chars < 10) begin
					$display("unexpected character: code %h last %b", char_code, last_char);
				end
				bad_chars++;
			end else begin
				want_char = expected_chars.pop_front();
				if (char_code !== want_char.code || last_char !== want_char.last) begin
					if (bad_chars < 10) begin
						$display("character %0d: expected code %h last %b, got code %h last %b",
							chars_taken, want_char.code, want_char.last, char_code, last_char);
					end
					bad_chars++;
				end
			end
		end
	end

	// Give up on a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

endmodule
